FILE: src/psg_pkg.sv
`default_nettype none

package psg_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int ADDR_W          = $clog2(PALETTE_ENTRIES);
	localparam int RGB_W           = 24;

	localparam int SHADE_LEVELS = 65;
	localparam logic [6:0] LEVEL_MAX   = 7'(SHADE_LEVELS - 1);
	localparam logic [6:0] LEVEL_DARK  = 7'd31;
	localparam logic [6:0] LEVEL_LIGHT = 7'd32;

	localparam logic [8:0]  CONTRAST_OFFSET = 9'd127;
	localparam logic [12:0] SHADE_SAT       = 13'd8191;
	localparam logic [7:0]  CHAN_MAX        = 8'd255;

	// ceil(2^K / d) reciprocals, exact for the stated input widths
	localparam logic [16:0] RECIP_255_16 = 17'd65794;
	localparam logic [25:0] RECIP_255_25 = 26'd33686019;
	localparam logic [20:0] RECIP_31_20  = 21'd1082402;

	// s1 is the palette read, s8 the last arithmetic stage
	localparam int LAST_STAGE = 8;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic {
		KIND_LOAD   = 1'b0,
		KIND_LOOKUP = 1'b1
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TINT_RED   = 3'd0,
		REG_TINT_GREEN = 3'd1,
		REG_TINT_BLUE  = 3'd2,
		REG_CONTRAST   = 3'd3,
		REG_BRIGHTNESS = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [LAST_STAGE:2] ld;
	} psg_ctl_t;

	function automatic logic [8:0] div255_16(input logic [15:0] x);
		logic [32:0] p;
		p = {17'b0, x} * {16'b0, RECIP_255_16};
		return p[32:24];
	endfunction

	function automatic logic [16:0] div255_25(input logic [24:0] x);
		logic [50:0] p;
		p = {26'b0, x} * {25'b0, RECIP_255_25};
		return p[49:33];
	endfunction

	function automatic logic [15:0] div31_20(input logic [19:0] x);
		logic [40:0] p;
		p = {21'b0, x} * {20'b0, RECIP_31_20};
		return p[40:25];
	endfunction

endpackage

`default_nettype wire

FILE: src/psg_in_if.sv
`default_nettype none

interface psg_in_if;
	logic                             valid;
	logic                             ready;
	psg_pkg::kind_t                   kind;
	logic [7:0]                       color_index;
	logic [6:0]                       shade_level;
	logic [7:0]                       load_red;
	logic [7:0]                       load_green;
	logic [7:0]                       load_blue;

	modport source (output valid, kind, color_index, shade_level,
		load_red, load_green, load_blue, input ready);
	modport sink (input valid, kind, color_index, shade_level,
		load_red, load_green, load_blue, output ready);
endinterface

`default_nettype wire

FILE: src/psg_out_if.sv
`default_nettype none

interface psg_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;

	modport source (output valid, out_red, out_green, out_blue, input ready);
	modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

`default_nettype wire

FILE: src/psg_cfg_if.sv
`default_nettype none

interface psg_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [psg_pkg::CFG_IDX_W-1:0]   index;
	logic [psg_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: src/psg_ram.sv
`default_nettype none

module psg_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: src/psg_lane.sv
`default_nettype none

module psg_lane (
	input  wire logic              clk,
	input  wire psg_pkg::psg_ctl_t ctl,
	input  wire logic [7:0]        base,
	input  wire logic [7:0]        tint,
	input  wire logic [15:0]       contrast,
	input  wire logic [8:0]        bright_hi,
	input  wire logic [7:0]        bright_lo,
	input  wire logic [6:0]        level,
	output logic      [7:0]        result
);
	import psg_pkg::*;

	// s2: tint
	logic [15:0] tprod;
	logic [16:0] tsum;
	logic [7:0]  t_s2;
	logic [6:0]  lvl_s2;
	// s3: contrast product
	logic [8:0]  toff;
	logic [24:0] xc_s3;
	logic [6:0]  lvl_s3;
	// s4: contrast quotient
	logic [16:0] qc_s4;
	logic [6:0]  lvl_s4;
	// s5: brightness split products
	logic [16:0] mag;
	logic        neg_s5;
	logic [25:0] phi_s5;
	logic [24:0] plo_s5;
	logic [6:0]  lvl_s5;
	// s6
	logic        neg_s6;
	logic [25:0] phi_s6;
	logic [16:0] qlo_s6;
	logic [6:0]  lvl_s6;
	// s7: saturate and shade product
	logic [26:0] c2;
	logic [12:0] cs;
	logic [6:0]  fac;
	logic        neg_s7;
	logic [12:0] cs_s7;
	logic [19:0] xs_s7;
	logic [6:0]  lvl_s7;
	// s8: shade quotient
	logic        neg_s8;
	logic [12:0] cs_s8;
	logic [15:0] qs_s8;
	logic [6:0]  lvl_s8;
	logic [15:0] shaded;

	assign tprod = {8'b0, base} * {8'b0, tint};
	// x/255 as (x + (x>>8) + 1) >> 8, exact below 65535
	assign tsum  = {1'b0, tprod} + {9'b0, tprod[15:8]} + 17'd1;
	assign toff  = {1'b0, t_s2} + CONTRAST_OFFSET;
	assign mag   = qc_s4 - {8'b0, CONTRAST_OFFSET};

	// brightness = m*(b/255) + m*(b%255)/255
	assign c2 = {1'b0, phi_s6} + {10'b0, qlo_s6};
	// past 8191 every level gives the same clamped result as the true value
	assign cs = (c2 > {14'b0, SHADE_SAT}) ? SHADE_SAT : c2[12:0];

	always_comb begin
		if (lvl_s6 < LEVEL_DARK) begin
			fac = lvl_s6;
		end else if (lvl_s6 > LEVEL_LIGHT) begin
			fac = 7'((lvl_s6 - LEVEL_DARK) << 1);
		end else begin
			fac = 7'd0;
		end
	end

	always_comb begin
		if (lvl_s8 < LEVEL_DARK) begin
			shaded = qs_s8;
		end else if (lvl_s8 > LEVEL_LIGHT) begin
			shaded = {3'b0, cs_s8} + qs_s8;
		end else begin
			shaded = {3'b0, cs_s8};
		end
	end

	always_comb begin
		if (neg_s8) begin
			result = 8'd0;
		end else if (shaded > {8'b0, CHAN_MAX}) begin
			result = CHAN_MAX;
		end else begin
			result = shaded[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld[2]) begin
			t_s2   <= tsum[15:8];
			lvl_s2 <= level;
		end
		if (ctl.ld[3]) begin
			xc_s3  <= {16'b0, toff} * {9'b0, contrast};
			lvl_s3 <= lvl_s2;
		end
		if (ctl.ld[4]) begin
			qc_s4  <= div255_25(xc_s3);
			lvl_s4 <= lvl_s3;
		end
		if (ctl.ld[5]) begin
			neg_s5 <= (qc_s4 < {8'b0, CONTRAST_OFFSET});
			phi_s5 <= {9'b0, mag} * {17'b0, bright_hi};
			plo_s5 <= {8'b0, mag} * {17'b0, bright_lo};
			lvl_s5 <= lvl_s4;
		end
		if (ctl.ld[6]) begin
			neg_s6 <= neg_s5;
			phi_s6 <= phi_s5;
			qlo_s6 <= div255_25(plo_s5);
			lvl_s6 <= lvl_s5;
		end
		if (ctl.ld[7]) begin
			neg_s7 <= neg_s6;
			cs_s7  <= cs;
			xs_s7  <= {7'b0, cs} * {13'b0, fac};
			lvl_s7 <= lvl_s6;
		end
		if (ctl.ld[8]) begin
			neg_s8 <= neg_s7;
			cs_s8  <= cs_s7;
			qs_s8  <= div31_20(xs_s7);
			lvl_s8 <= lvl_s7;
		end
	end

endmodule

`default_nettype wire

FILE: src/palette_shade_generator.sv
`default_nettype none

// A lookup item's result passes through the palette read, then seven arithmetic
// stages, then the output register. Throughput: one item per clock while the
// result port does not stall, loads and lookups alike; loads give no result.
// Pipeline stages advance independently, so bubbles close up under a stall.
// Reset clears all valids and returns the gains to 255; palette contents stay
// undefined until loaded.

module palette_shade_generator (
	input  wire logic clk,
	input  wire logic arst_n,
	psg_in_if.sink    lookup,
	psg_out_if.source result,
	psg_cfg_if.sink   cfg
);
	import psg_pkg::*;

	logic [LAST_STAGE+1:1] adv;
	logic [LAST_STAGE:1]   v_q;
	logic                  out_valid_q;
	logic [7:0]            out_r_q;
	logic [7:0]            out_g_q;
	logic [7:0]            out_b_q;

	logic [7:0]  tint_r_q;
	logic [7:0]  tint_g_q;
	logic [7:0]  tint_b_q;
	logic [15:0] contrast_q;
	logic [8:0]  bright_hi_q;
	logic [7:0]  bright_lo_q;

	logic [8:0]  wr_hi;
	logic [16:0] wr_lo;

	logic        accept;
	logic [6:0]  lvl_in;
	logic [6:0]  lvl_s1;
	logic [RGB_W-1:0] base_s1;
	psg_ctl_t    ctl;
	logic [7:0]  res_r;
	logic [7:0]  res_g;
	logic [7:0]  res_b;

	always_comb begin
		adv[LAST_STAGE+1] = !out_valid_q || result.ready;
		for (int k = LAST_STAGE; k >= 1; k--) begin
			adv[k] = !v_q[k] || adv[k+1];
		end
	end

	assign lookup.ready = adv[1];
	assign accept       = lookup.valid && adv[1];
	assign lvl_in       = (lookup.shade_level > LEVEL_MAX) ? LEVEL_MAX : lookup.shade_level;
	assign ctl.ld       = adv[LAST_STAGE:2];

	psg_ram #(
		.WIDTH(RGB_W),
		.DEPTH(PALETTE_ENTRIES)
	) u_palette (
		.clk  (clk),
		.we   (accept && lookup.kind == KIND_LOAD),
		.waddr(lookup.color_index[ADDR_W-1:0]),
		.wdata({lookup.load_red, lookup.load_green, lookup.load_blue}),
		.re   (adv[1]),
		.raddr(lookup.color_index[ADDR_W-1:0]),
		.rdata(base_s1)
	);

	psg_lane u_lane_r (
		.clk      (clk),
		.ctl      (ctl),
		.base     (base_s1[23:16]),
		.tint     (tint_r_q),
		.contrast (contrast_q),
		.bright_hi(bright_hi_q),
		.bright_lo(bright_lo_q),
		.level    (lvl_s1),
		.result   (res_r)
	);

	psg_lane u_lane_g (
		.clk      (clk),
		.ctl      (ctl),
		.base     (base_s1[15:8]),
		.tint     (tint_g_q),
		.contrast (contrast_q),
		.bright_hi(bright_hi_q),
		.bright_lo(bright_lo_q),
		.level    (lvl_s1),
		.result   (res_g)
	);

	psg_lane u_lane_b (
		.clk      (clk),
		.ctl      (ctl),
		.base     (base_s1[7:0]),
		.tint     (tint_b_q),
		.contrast (contrast_q),
		.bright_hi(bright_hi_q),
		.bright_lo(bright_lo_q),
		.level    (lvl_s1),
		.result   (res_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv[1]) begin
				v_q[1] <= accept && lookup.kind == KIND_LOOKUP;
			end
			for (int k = 2; k <= LAST_STAGE; k++) begin
				if (adv[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
			if (adv[LAST_STAGE+1]) begin
				out_valid_q <= v_q[LAST_STAGE];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			lvl_s1 <= lvl_in;
		end
		if (adv[LAST_STAGE+1]) begin
			out_r_q <= res_r;
			out_g_q <= res_g;
			out_b_q <= res_b;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.out_red   = out_r_q;
	assign result.out_green = out_g_q;
	assign result.out_blue  = out_b_q;

	// brightness kept as quotient and remainder of gain/255
	assign wr_hi = div255_16(cfg.data);
	assign wr_lo = {1'b0, cfg.data} - ({wr_hi, 8'b0} - {8'b0, wr_hi});

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tint_r_q    <= 8'd255;
			tint_g_q    <= 8'd255;
			tint_b_q    <= 8'd255;
			contrast_q  <= 16'd255;
			bright_hi_q <= 9'd1;
			bright_lo_q <= 8'd0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_TINT_RED: begin
					tint_r_q <= cfg.data[7:0];
				end
				REG_TINT_GREEN: begin
					tint_g_q <= cfg.data[7:0];
				end
				REG_TINT_BLUE: begin
					tint_b_q <= cfg.data[7:0];
				end
				REG_CONTRAST: begin
					contrast_q <= cfg.data;
				end
				REG_BRIGHTNESS: begin
					bright_hi_q <= wr_hi;
					bright_lo_q <= wr_lo[7:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: tb/tb_palette_shade_generator.sv
`timescale 1ns / 100ps

module tb_palette_shade_generator;
	import psg_pkg::*;

	localparam int SETTLE_CYCLES   = LAST_STAGE + 4;
	localparam int DRAIN_LIMIT     = 20000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int MAX_PRINTED     = 30;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct {
		kind_t      kind;
		logic [7:0] index;
		logic [6:0] level;
		rgb_t       load;
	} pal_op_t;

	typedef enum int {
		STALL_NONE,
		STALL_COIN,
		STALL_LIGHT,
		STALL_PERIODIC
	} stall_mode_t;

	logic clk;
	logic arst_n;

	psg_in_if  lookup_if ();
	psg_out_if result_if ();
	psg_cfg_if cfg_if ();

	palette_shade_generator u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.lookup (lookup_if),
		.result (result_if),
		.cfg    (cfg_if)
	);

	// shadow of the palette and gain registers
	rgb_t        base_rgb [PALETTE_ENTRIES];
	bit          loaded [PALETTE_ENTRIES];
	logic [7:0]  loaded_list [$];
	logic [7:0]  tint_gain [3];
	logic [15:0] contrast_mult;
	logic [15:0] bright_mult;
	rgb_t        pending_colors [$];

	int errors             = 0;
	int loads_sent         = 0;
	int lookups_sent       = 0;
	int colors_checked     = 0;
	int settings_used      = 0;
	int input_stall_cycles = 0;
	int burst_left         = 0;
	bit idle_enable        = 1'b1;
	int hold_off_req       = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Run exceeded its time limit");
		$display("Verification failed");
		$finish;
	end

	task automatic report_mismatch(string msg);
		errors++;
		if (errors <= MAX_PRINTED)
			$display("[%0t] MISMATCH %s", $time, msg);
	endtask

	// signed math, divisions truncate toward zero
	function automatic logic [7:0] shaded_component(logic [7:0] base, logic [7:0] tint,
			logic [6:0] level);
		longint c;
		c = longint'(base) * longint'(tint) / 255;
		c = (c + 127) * longint'(contrast_mult) / 255 - 127;
		c = c * longint'(bright_mult) / 255;
		if (level < LEVEL_DARK) begin
			c = c * longint'(level) / 31;
		end else if (level > LEVEL_LIGHT) begin
			c = c + c * ((longint'(level) - 31) * 2) / 31;
		end
		if (c < 0)
			c = 0;
		else if (c > 255)
			c = 255;
		return c[7:0];
	endfunction

	function automatic rgb_t shaded_color(logic [7:0] index, logic [6:0] level_in);
		logic [6:0] level;
		rgb_t       base;
		rgb_t       c;
		level   = (level_in > LEVEL_MAX) ? LEVEL_MAX : level_in;
		base    = base_rgb[index];
		c.red   = shaded_component(base.red, tint_gain[0], level);
		c.green = shaded_component(base.green, tint_gain[1], level);
		c.blue  = shaded_component(base.blue, tint_gain[2], level);
		return c;
	endfunction

	function automatic logic [6:0] random_level();
		case ($urandom_range(0, 9))
			0: return LEVEL_DARK;
			1: return LEVEL_LIGHT;
			2: return 7'($urandom_range(65, 127));
			default: return 7'($urandom_range(0, 64));
		endcase
	endfunction

	// lookups only go to entries that have been loaded
	function automatic pal_op_t random_op(int load_pct);
		pal_op_t op;
		op.index = 8'($urandom);
		op.level = random_level();
		op.load  = 24'($urandom);
		if (loaded_list.size() == 0 || $urandom_range(0, 99) < load_pct) begin
			op.kind = KIND_LOAD;
		end else begin
			op.kind  = KIND_LOOKUP;
			op.index = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
		end
		return op;
	endfunction

	function automatic logic [15:0] random_tint();
		logic [7:0] low;
		case ($urandom_range(0, 3))
			0: low = 8'h00;
			1: low = 8'hFF;
			default: low = 8'($urandom);
		endcase
		return {8'($urandom), low};
	endfunction

	function automatic logic [15:0] random_gain();
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 255));
			default: return 16'($urandom_range(200, 320));
		endcase
	endfunction

	// called at a rising edge, returns at the edge where the item is taken
	task automatic send_op(pal_op_t op);
		if (idle_enable && burst_left == 0) begin
			lookup_if.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		if (burst_left > 0)
			burst_left--;
		lookup_if.valid       <= 1'b1;
		lookup_if.kind        <= op.kind;
		lookup_if.color_index <= op.index;
		lookup_if.shade_level <= op.level;
		lookup_if.load_red    <= op.load.red;
		lookup_if.load_green  <= op.load.green;
		lookup_if.load_blue   <= op.load.blue;
		@(negedge clk);
		while (!lookup_if.ready) begin
			input_stall_cycles++;
			@(negedge clk);
		end
		if (op.kind == KIND_LOAD) begin
			base_rgb[op.index] = op.load;
			if (!loaded[op.index]) begin
				loaded[op.index] = 1'b1;
				loaded_list.push_back(op.index);
			end
			loads_sent++;
		end else begin
			pending_colors.push_back(shaded_color(op.index, op.level));
			lookups_sent++;
		end
		@(posedge clk);
	endtask

	task automatic send_ops(int count, int load_pct);
		repeat (count) send_op(random_op(load_pct));
	endtask

	task automatic load_entry(logic [7:0] index, rgb_t rgb, logic [6:0] junk_level);
		pal_op_t op;
		op.kind  = KIND_LOAD;
		op.index = index;
		op.level = junk_level;
		op.load  = rgb;
		send_op(op);
	endtask

	task automatic look_up(logic [7:0] index, logic [6:0] level, rgb_t junk_rgb);
		pal_op_t op;
		op.kind  = KIND_LOOKUP;
		op.index = index;
		op.level = level;
		op.load  = junk_rgb;
		send_op(op);
	endtask

	// leaves cfg valid high; the caller lowers it after the last write
	task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= index;
		cfg_if.data  <= value;
		@(negedge clk);
		while (!cfg_if.ready) @(negedge clk);
		case (index)
			REG_TINT_RED:   tint_gain[0]  = value[7:0];
			REG_TINT_GREEN: tint_gain[1]  = value[7:0];
			REG_TINT_BLUE:  tint_gain[2]  = value[7:0];
			REG_CONTRAST:   contrast_mult = value;
			REG_BRIGHTNESS: bright_mult   = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic program_gains(logic [15:0] tr, logic [15:0] tg, logic [15:0] tb,
			logic [15:0] con, logic [15:0] bri, bit with_unused);
		write_reg(REG_TINT_RED, tr);
		write_reg(REG_TINT_GREEN, tg);
		write_reg(REG_TINT_BLUE, tb);
		write_reg(REG_CONTRAST, con);
		write_reg(REG_BRIGHTNESS, bri);
		// indexes past the register list must be dropped
		if (with_unused) begin
			for (int i = int'(REG_BRIGHTNESS) + 1; i < (1 << CFG_IDX_W); i++)
				write_reg(CFG_IDX_W'(i), 16'($urandom));
		end
		cfg_if.valid <= 1'b0;
		settings_used++;
	endtask

	task automatic program_random_gains();
		program_gains(random_tint(), random_tint(), random_tint(), random_gain(),
			random_gain(), 1'b0);
	endtask

	// wait out every expected color, then idle so that any unexpected color still in the pipe shows up
	task automatic settle();
		int waited;
		waited = 0;
		lookup_if.valid <= 1'b0;
		while (pending_colors.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_colors.size() != 0) begin
			report_mismatch($sformatf("%0d expected colors never arrived",
				pending_colors.size()));
			pending_colors.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_directed();
		logic [6:0] levels [10] = '{7'd0, 7'd1, 7'd30, 7'd31, 7'd32, 7'd33, 7'd63,
			7'd64, 7'd65, 7'd127};
		load_entry(8'h00, 24'h000000, 7'h00);
		load_entry(8'hFF, 24'hFFFFFF, 7'h7F);
		load_entry(8'h55, 24'hAA550F, 7'h2A);
		load_entry(8'hAA, 24'h807F01, 7'h55);
		foreach (levels[i])
			look_up(8'hFF, levels[i], (i % 2) ? 24'hFFFFFF : 24'h000000);
		look_up(8'h00, 7'd64, 24'h5A5A5A);
		look_up(8'h55, LEVEL_DARK, 24'h000000);
		look_up(8'hAA, 7'd40, 24'hA5A5A5);
		// overwrite followed by a read of the same entry
		load_entry(8'h55, 24'h12F0C3, 7'h00);
		look_up(8'h55, 7'd50, 24'hFFFFFF);
		load_entry(8'h01, 24'h7F8001, 7'h40);
		look_up(8'h01, 7'd10, 24'h000000);
		settle();
	endtask

	task automatic test_gain_extremes();
		program_gains(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
		send_ops(50, 25);
		settle();
		program_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		send_ops(50, 25);
		settle();
		program_gains(16'hFF00, 16'hFF00, 16'hFF00, 16'hFFFF, 16'hFFFF, 1'b0);
		send_ops(50, 25);
		settle();
		// zero contrast drives every channel negative before the clamp
		program_gains(16'h00FF, 16'h00FF, 16'h00FF, 16'h0000, 16'hFFFF, 1'b0);
		send_ops(50, 25);
		settle();
		program_gains(16'h00FF, 16'h00FF, 16'h00FF, 16'h00FF, 16'h00FF, 1'b1);
		send_ops(50, 25);
		settle();
	endtask

	task automatic test_random_gains();
		repeat (5) begin
			program_random_gains();
			send_ops(140, 30);
			settle();
		end
	endtask

	task automatic test_backpressure();
		program_random_gains();
		hold_off_req = HOLD_OFF_CYCLES;
		idle_enable  = 1'b0;
		send_ops(100, 20);
		idle_enable = 1'b1;
		settle();
	endtask

	// result port stall pattern, plus the long hold-off on request
	initial begin
		stall_mode_t mode;
		int          mode_left;
		int          tick;
		int          hold_left;
		mode      = STALL_NONE;
		mode_left = 0;
		tick      = 0;
		hold_left = 0;
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req != 0) begin
				hold_left    = hold_off_req;
				hold_off_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_if.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = stall_mode_t'($urandom_range(int'(STALL_NONE),
						int'(STALL_PERIODIC)));
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				tick++;
				case (mode)
					STALL_NONE:     result_if.ready <= 1'b1;
					STALL_COIN:     result_if.ready <= 1'($urandom_range(0, 1));
					STALL_LIGHT:    result_if.ready <= ($urandom_range(0, 3) != 0);
					STALL_PERIODIC: result_if.ready <= (tick % 3 == 0);
					default:        result_if.ready <= 1'b1;
				endcase
			end
		end
	end

	// handshake signals are stable at the falling edge
	initial begin
		rgb_t want;
		forever begin
			@(negedge clk);
			if (result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
				if (pending_colors.size() == 0) begin
					report_mismatch($sformatf("unexpected color %02h %02h %02h",
						result_if.out_red, result_if.out_green, result_if.out_blue));
				end else begin
					want = pending_colors.pop_front();
					colors_checked++;
					if (result_if.out_red !== want.red)
						report_mismatch($sformatf("red got %02h want %02h",
							result_if.out_red, want.red));
					if (result_if.out_green !== want.green)
						report_mismatch($sformatf("green got %02h want %02h",
							result_if.out_green, want.green));
					if (result_if.out_blue !== want.blue)
						report_mismatch($sformatf("blue got %02h want %02h",
							result_if.out_blue, want.blue));
				end
			end
		end
	end

	initial begin
		arst_n                <= 1'b0;
		lookup_if.valid       <= 1'b0;
		lookup_if.kind        <= KIND_LOAD;
		lookup_if.color_index <= '0;
		lookup_if.shade_level <= '0;
		lookup_if.load_red    <= '0;
		lookup_if.load_green  <= '0;
		lookup_if.load_blue   <= '0;
		cfg_if.valid          <= 1'b0;
		cfg_if.index          <= REG_TINT_RED;
		cfg_if.data           <= '0;
		tint_gain[0]  = 8'hFF;
		tint_gain[1]  = 8'hFF;
		tint_gain[2]  = 8'hFF;
		contrast_mult = 16'd255;
		bright_mult   = 16'd255;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed();
		test_gain_extremes();
		test_random_gains();
		test_backpressure();

		$display("Covered %0d palette loads and %0d shaded lookups over %0d gain settings",
			loads_sent, lookups_sent, settings_used + 1);
		$display("%0d colors compared, %0d of %0d entries loaded, input held %0d cycles",
			colors_checked, loaded_list.size(), PALETTE_ENTRIES, input_stall_cycles);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
